// File: rtl/dsd_pkg.sv
package dsd_pkg;

   localparam int VALUE_W = 32;

   typedef enum logic [0:0] {
      ST_INTAKE,
      ST_DRAIN
   } state_type;

   typedef struct packed {
      logic insert;
      logic pop;
   } cmd_type;

   typedef struct packed {
      logic count_one;
   } status_type;

endpackage

// File: rtl/dsd_datapath.sv
module dsd_datapath #(
   parameter int CAPACITY = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  dsd_pkg::cmd_type                  cmd,
   output dsd_pkg::status_type               status,
   input  logic signed [dsd_pkg::VALUE_W-1:0] req_value,
   output logic signed [dsd_pkg::VALUE_W-1:0] rsp_value,
   output logic                              rsp_last,
   output logic                              rsp_overflow
);
   import dsd_pkg::*;

   localparam int CNT_W = $clog2(CAPACITY + 1);

   logic signed [VALUE_W-1:0] cell_ff [CAPACITY];
   logic signed [VALUE_W-1:0] cell_in [CAPACITY];
   logic [CNT_W-1:0]          count_ff, count_in;
   logic                      dropped_ff, dropped_in;
   logic signed [VALUE_W-1:0] out_value_ff, out_value_in;
   logic                      out_last_ff, out_last_in;
   logic                      out_overflow_ff, out_overflow_in;

   logic [CAPACITY-1:0] valid;
   logic [CAPACITY-1:0] match;
   logic [CAPACITY-1:0] take;
   logic                any_match;
   logic                full;
   logic                do_insert;
   logic                count_one;

   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         valid[i] = CNT_W'(i) < count_ff;
         match[i] = valid[i] && (cell_ff[i] == req_value);
         take[i]  = !valid[i] || (cell_ff[i] < req_value);
      end
   end

   assign any_match = |match;
   assign full      = count_ff == CNT_W'(CAPACITY);
   assign do_insert = cmd.insert && !any_match && !full;
   assign count_one = count_ff == CNT_W'(1);
   assign status.count_one = count_one;

   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         cell_in[i] = cell_ff[i];
         if (do_insert && take[i]) begin
            if (i == 0) begin
               cell_in[i] = req_value;
            end else if (!take[i-1]) begin
               cell_in[i] = req_value;
            end else begin
               cell_in[i] = cell_ff[i-1];
            end
         end else if (cmd.pop && i < CAPACITY - 1) begin
            cell_in[i] = cell_ff[i+1];
         end
      end
   end

   always_comb begin
      count_in        = count_ff;
      dropped_in      = dropped_ff;
      out_value_in    = out_value_ff;
      out_last_in     = out_last_ff;
      out_overflow_in = out_overflow_ff;
      if (cmd.insert) begin
         if (do_insert) begin
            count_in = count_ff + CNT_W'(1);
         end else if (!any_match) begin
            dropped_in = 1'b1;
         end
      end else if (cmd.pop) begin
         out_value_in    = cell_ff[0];
         out_last_in     = count_one;
         out_overflow_in = dropped_ff;
         count_in        = count_ff - CNT_W'(1);
         if (count_one) begin
            dropped_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         dropped_ff <= 1'b0;
      end else begin
         count_ff   <= count_in;
         dropped_ff <= dropped_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < CAPACITY; i++) begin
         cell_ff[i] <= cell_in[i];
      end
      out_value_ff    <= out_value_in;
      out_last_ff     <= out_last_in;
      out_overflow_ff <= out_overflow_in;
   end

   assign rsp_value    = out_value_ff;
   assign rsp_last     = out_last_ff;
   assign rsp_overflow = out_overflow_ff;

endmodule

// File: rtl/dsd_controller.sv
module dsd_controller (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic                req_tlast,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output dsd_pkg::cmd_type    cmd,
   input  dsd_pkg::status_type status
);
   import dsd_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept;

   assign accept = req_tvalid && req_tready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_INTAKE: begin
            if (accept && req_tlast) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (cmd.pop && status.count_one) begin
               state_in = ST_INTAKE;
            end
         end
         default: state_in = ST_INTAKE;
      endcase
   end

   always_comb begin
      req_tready = 1'b0;
      cmd.insert = 1'b0;
      cmd.pop    = 1'b0;
      case (state_ff)
         ST_INTAKE: begin
            req_tready = 1'b1;
            cmd.insert = req_tvalid;
         end
         ST_DRAIN: begin
            cmd.pop = !rsp_valid_ff || rsp_tready;
         end
         default: ;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.pop) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INTAKE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

// File: rtl/dedup_sort_descending.sv
// Intake: one request per cycle; each value is compared against all stored cells and
// inserted into the sorted row in the same cycle.
// Drain: once the request marked tlast is accepted, the state register moves to drain and the
// first pop loads the output register, raising rsp_tvalid; then one result per cycle for each
// distinct value while rsp_tready is high, shifted from the row head; req_tready is low meanwhile.
// Reset: synchronous, active high; clears the count, overflow flag, state and rsp_tvalid.
module dedup_sort_descending #(
   parameter int CAPACITY = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] value
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] value_res
   output logic        rsp_tlast,
   output logic        rsp_tuser    // [0] overflow
);
   import dsd_pkg::*;

   cmd_type                   cmd;
   status_type                status;
   logic signed [VALUE_W-1:0] rsp_value;

   dsd_controller u_controller (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .status     (status)
   );

   dsd_datapath #(
      .CAPACITY (CAPACITY)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .req_value    (signed'(req_tdata)),
      .rsp_value    (rsp_value),
      .rsp_last     (rsp_tlast),
      .rsp_overflow (rsp_tuser)
   );

   assign rsp_tdata = unsigned'(rsp_value);

endmodule
